// ===== hw/rtl/uvst_pkg.sv =====
// Shared types, constants and arithmetic helpers of the UV sphere cell tessellator.
`default_nettype none
package uvst_pkg;

  localparam int ANGLE_W   = 32;
  localparam int CORD_W    = 33;
  localparam int DIV_CHUNK = 4;
  localparam int ATAN_ENTRIES = 24;

  localparam logic [30:0] RADIUS_RESET   = 31'd65536;
  localparam logic [7:0]  LON_STEPS_RESET = 8'd20;
  localparam logic [7:0]  LAT_STEPS_RESET = 8'd30;

  localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic [ANGLE_W-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [2:0] LAST_CORNER = 3'd5;

  typedef enum logic [2:0] {
    REG_RADIUS    = 3'd0,
    REG_CENTER_X  = 3'd1,
    REG_CENTER_Y  = 3'd2,
    REG_CENTER_Z  = 3'd3,
    REG_LON_STEPS = 3'd4,
    REG_LAT_STEPS = 3'd5
  } reg_index_t;

  localparam logic [ANGLE_W-1:0] ATAN_TURNS [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct packed {
    logic [7:0] lat_index;
    logic [7:0] lon_index;
  } cell_t;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
    logic [2:0]         corner_number;
    logic               last_vertex;
  } vertex_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] corner;
  } tag_t;

  typedef struct packed {
    logic signed [CORD_W-1:0] x;
    logic signed [CORD_W-1:0] y;
    logic signed [CORD_W-1:0] z;
    logic [1:0]               quad;
  } cordic_t;

  typedef struct packed {
    logic signed [CORD_W-1:0] c;
    logic signed [CORD_W-1:0] s;
  } sincos_t;

  // Corner sequence (v1,v2,v3),(v2,v4,v3): bit 0 steps latitude, bit 1 longitude.
  function automatic logic [1:0] corner_offset(input logic [2:0] corner);
    logic [1:0] off;
    unique case (corner)
      3'd0:    off = 2'b00;
      3'd1:    off = 2'b01;
      3'd2:    off = 2'b10;
      3'd3:    off = 2'b01;
      3'd4:    off = 2'b11;
      3'd5:    off = 2'b10;
      default: off = 2'b00;
    endcase
    return off;
  endfunction

  // Four restoring division steps; rem stays below d.
  function automatic logic [11:0] div_chunk(input logic [7:0] rem, input logic [3:0] nb,
                                            input logic [7:0] d);
    logic [8:0] t;
    logic [7:0] r;
    logic [3:0] q;
    r = rem;
    q = '0;
    for (int b = 3; b >= 0; b--) begin
      t = {r, nb[b[1:0]]};
      if (t >= {1'b0, d}) begin
        r = 8'(t - {1'b0, d});
        q[b[1:0]] = 1'b1;
      end else begin
        r = t[7:0];
      end
    end
    return {r, q};
  endfunction

  function automatic cordic_t cordic_step(input cordic_t c, input int k);
    cordic_t r;
    logic signed [CORD_W-1:0] dx;
    logic signed [CORD_W-1:0] dy;
    logic signed [CORD_W-1:0] at;
    r  = c;
    dx = c.y >>> k;
    dy = c.x >>> k;
    at = $signed({1'b0, ATAN_TURNS[k[4:0]]});
    if (!c.z[CORD_W-1]) begin
      r.x = c.x - dx;
      r.y = c.y + dy;
      r.z = c.z - at;
    end else begin
      r.x = c.x + dx;
      r.y = c.y - dy;
      r.z = c.z + at;
    end
    return r;
  endfunction

  function automatic sincos_t quad_map(input cordic_t c);
    sincos_t r;
    case (c.quad)
      2'd0:    begin r.c = c.x;  r.s = c.y;  end
      2'd1:    begin r.c = -c.y; r.s = c.x;  end
      2'd2:    begin r.c = -c.x; r.s = -c.y; end
      default: begin r.c = c.y;  r.s = -c.x; end
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -40'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/uvst_divider.sv =====
// Pipelined restoring dividers for the longitude and latitude binary angles.
`default_nettype none
module uvst_divider #(
  parameter int NUM_BITS = 41
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire uvst_pkg::tag_t               tag_in,
  input  wire logic [NUM_BITS-1:0]          num_phi,
  input  wire logic [NUM_BITS-1:0]          num_theta,
  input  wire logic [7:0]                   div_phi,
  input  wire logic [7:0]                   div_theta,
  output uvst_pkg::tag_t                    tag_out,
  output logic [uvst_pkg::ANGLE_W-1:0]      q_phi,
  output logic [uvst_pkg::ANGLE_W-1:0]      q_theta
);
  import uvst_pkg::*;

  localparam int STAGES = (NUM_BITS + DIV_CHUNK - 1) / DIV_CHUNK;
  localparam int TOT    = STAGES * DIV_CHUNK;

  logic [7:0]         rp [STAGES];
  logic [7:0]         rt [STAGES];
  logic [TOT-1:0]     np [STAGES];
  logic [TOT-1:0]     nt [STAGES];
  logic [ANGLE_W-1:0] qp [STAGES];
  logic [ANGLE_W-1:0] qt [STAGES];
  tag_t               tg [STAGES];

  logic [7:0]         rp_in [STAGES];
  logic [7:0]         rt_in [STAGES];
  logic [TOT-1:0]     np_in [STAGES];
  logic [TOT-1:0]     nt_in [STAGES];
  logic [ANGLE_W-1:0] qp_in [STAGES];
  logic [ANGLE_W-1:0] qt_in [STAGES];
  tag_t               tg_in [STAGES];
  logic [11:0]        ch_p  [STAGES];
  logic [11:0]        ch_t  [STAGES];

  always_comb begin
    for (int s = 0; s < STAGES; s++) begin
      if (s == 0) begin
        rp_in[s] = '0;
        rt_in[s] = '0;
        np_in[s] = TOT'(num_phi);
        nt_in[s] = TOT'(num_theta);
        qp_in[s] = '0;
        qt_in[s] = '0;
        tg_in[s] = tag_in;
      end else begin
        rp_in[s] = rp[s-1];
        rt_in[s] = rt[s-1];
        np_in[s] = np[s-1];
        nt_in[s] = nt[s-1];
        qp_in[s] = qp[s-1];
        qt_in[s] = qt[s-1];
        tg_in[s] = tg[s-1];
      end
      ch_p[s] = div_chunk(rp_in[s], np_in[s][TOT-1 -: DIV_CHUNK], div_phi);
      ch_t[s] = div_chunk(rt_in[s], nt_in[s][TOT-1 -: DIV_CHUNK], div_theta);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < STAGES; s++) begin
        rp[s] <= ch_p[s][11:4];
        rt[s] <= ch_t[s][11:4];
        np[s] <= np_in[s] << DIV_CHUNK;
        nt[s] <= nt_in[s] << DIV_CHUNK;
        qp[s] <= {qp_in[s][ANGLE_W-DIV_CHUNK-1:0], ch_p[s][3:0]};
        qt[s] <= {qt_in[s][ANGLE_W-DIV_CHUNK-1:0], ch_t[s][3:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < STAGES; s++) tg[s] <= '0;
    end else if (en) begin
      for (int s = 0; s < STAGES; s++) tg[s] <= tg_in[s];
    end
  end

  assign tag_out = tg[STAGES-1];
  assign q_phi   = qp[STAGES-1];
  assign q_theta = qt[STAGES-1];

endmodule
`default_nettype wire

// ===== hw/rtl/uvst_cordic.sv =====
// Pipelined rotation CORDIC, one step per stage, for both vertex angles.
`default_nettype none
module uvst_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire uvst_pkg::tag_t           tag_in,
  input  wire logic [uvst_pkg::ANGLE_W-1:0] ang_theta,
  input  wire logic [uvst_pkg::ANGLE_W-1:0] ang_phi,
  output uvst_pkg::tag_t                tag_out,
  output uvst_pkg::sincos_t             sc_theta,
  output uvst_pkg::sincos_t             sc_phi
);
  import uvst_pkg::*;

  cordic_t st_t  [CORDIC_STEPS];
  cordic_t st_p  [CORDIC_STEPS];
  tag_t    tg    [CORDIC_STEPS];
  cordic_t in_t  [CORDIC_STEPS];
  cordic_t in_p  [CORDIC_STEPS];
  tag_t    tg_in [CORDIC_STEPS];
  cordic_t init_t;
  cordic_t init_p;

  always_comb begin
    init_t.x    = CORDIC_GAIN;
    init_t.y    = '0;
    init_t.z    = $signed({3'b000, ang_theta[29:0]});
    init_t.quad = ang_theta[31:30];
    init_p.x    = CORDIC_GAIN;
    init_p.y    = '0;
    init_p.z    = $signed({3'b000, ang_phi[29:0]});
    init_p.quad = ang_phi[31:30];
    for (int s = 0; s < CORDIC_STEPS; s++) begin
      if (s == 0) begin
        in_t[s]  = init_t;
        in_p[s]  = init_p;
        tg_in[s] = tag_in;
      end else begin
        in_t[s]  = st_t[s-1];
        in_p[s]  = st_p[s-1];
        tg_in[s] = tg[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < CORDIC_STEPS; s++) begin
        st_t[s] <= cordic_step(in_t[s], s);
        st_p[s] <= cordic_step(in_p[s], s);
      end
      sc_theta <= quad_map(st_t[CORDIC_STEPS-1]);
      sc_phi   <= quad_map(st_p[CORDIC_STEPS-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < CORDIC_STEPS; s++) tg[s] <= '0;
      tag_out <= '0;
    end else if (en) begin
      for (int s = 0; s < CORDIC_STEPS; s++) tg[s] <= tg_in[s];
      tag_out <= tg[CORDIC_STEPS-1];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/uvst_vertex_math.sv =====
// Scale by radius, round, offset by center and saturate; ends in the output register.
`default_nettype none
module uvst_vertex_math (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire uvst_pkg::tag_t     tag_in,
  input  wire uvst_pkg::sincos_t  sc_theta,
  input  wire uvst_pkg::sincos_t  sc_phi,
  input  wire logic [30:0]        radius,
  input  wire logic signed [31:0] center_x,
  input  wire logic signed [31:0] center_y,
  input  wire logic signed [31:0] center_z,
  output logic                    vertex_valid,
  output uvst_pkg::vertex_t       vertex
);
  import uvst_pkg::*;

  localparam logic signed [64:0] HALF65 = 65'sd536870912;
  localparam logic signed [67:0] HALF68 = 68'sd536870912;

  // multiply by radius
  logic signed [64:0]       pr1, pz1;
  sincos_t                  phi1;
  tag_t                     tg1;
  // round
  logic signed [34:0]       rc2;
  logic signed [31:0]       z2;
  sincos_t                  phi2;
  tag_t                     tg2;
  // multiply by phi terms
  logic signed [67:0]       px3, py3;
  logic signed [31:0]       z3;
  tag_t                     tg3;

  logic signed [64:0] pr_rnd, pz_rnd;
  logic signed [67:0] px_rnd, py_rnd;
  logic signed [39:0] z_sum, x_sum, y_sum;

  always_comb begin
    pr_rnd = pr1 + HALF65;
    pz_rnd = pz1 + HALF65;
    z_sum  = {{5{pz_rnd[64]}}, pz_rnd[64:30]} + {{8{center_z[31]}}, center_z};
    px_rnd = px3 + HALF68;
    py_rnd = py3 + HALF68;
    x_sum  = {{2{px_rnd[67]}}, px_rnd[67:30]} + {{8{center_x[31]}}, center_x};
    y_sum  = {{2{py_rnd[67]}}, py_rnd[67:30]} + {{8{center_y[31]}}, center_y};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr1  <= $signed({1'b0, radius}) * sc_theta.c;
      pz1  <= $signed({1'b0, radius}) * sc_theta.s;
      phi1 <= sc_phi;
      rc2  <= pr_rnd[64:30];
      z2   <= sat32(z_sum);
      phi2 <= phi1;
      px3  <= rc2 * phi2.c;
      py3  <= rc2 * phi2.s;
      z3   <= z2;
      vertex.vertex_x      <= sat32(x_sum);
      vertex.vertex_y      <= sat32(y_sum);
      vertex.vertex_z      <= z3;
      vertex.corner_number <= tg3.corner;
      vertex.last_vertex   <= (tg3.corner == LAST_CORNER);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tg1 <= '0;
      tg2 <= '0;
      tg3 <= '0;
      vertex_valid <= 1'b0;
    end else if (en) begin
      tg1 <= tag_in;
      tg2 <= tg1;
      tg3 <= tg2;
      vertex_valid <= tg3.valid;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/uv_sphere_cell_tessellator.sv =====
// UV sphere cell tessellator: one grid cell in, six triangle vertices out.
// Cells pass the sequencer, divider, CORDIC and vertex math in turn; vertices come out one
// per cycle. The six-vertex sequencer takes the next cell as the last corner of the current
// one issues, feeding a pipeline that takes one vertex per cycle; the whole pipeline stalls
// only on the output register.
// Reset: synchronous; empties the pipeline and loads radius 1.0, center 0, 20x30 steps.
`default_nettype none
module uv_sphere_cell_tessellator #(
  parameter int INDEX_BITS   = 8,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cell_valid,
  output logic                   cell_ready,
  input  wire uvst_pkg::cell_t   grid_cell,
  output logic                   vertex_valid,
  input  wire logic              vertex_ready,
  output uvst_pkg::vertex_t      vertex,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [31:0]       cfg_data
);
  import uvst_pkg::*;

  localparam int AW       = INDEX_BITS + 1;    // vertex index may reach the step count
  localparam int NUM_BITS = AW + ANGLE_W;

  // configuration registers
  logic [30:0]        radius;
  logic signed [31:0] center_x, center_y, center_z;
  logic [7:0]         lon_steps, lat_steps;

  // sequencer
  logic                  busy;
  logic [2:0]            cnt;
  logic [INDEX_BITS-1:0] cell_i, cell_j;

  logic                  en;
  logic                  issue;
  logic [19:0]           lat_w, lon_w;
  logic [1:0]            off;
  logic [AW-1:0]         va, vb;
  logic [7:0]            lon_div, lat_div;
  logic [NUM_BITS-1:0]   num_phi, num_theta;
  tag_t                  seq_tag, div_tag, cor_tag;
  logic [ANGLE_W-1:0]    q_phi, q_theta, theta;
  sincos_t               sc_theta, sc_phi;

  // Write configuration at any time; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius    <= RADIUS_RESET;
      center_x  <= '0;
      center_y  <= '0;
      center_z  <= '0;
      lon_steps <= LON_STEPS_RESET;
      lat_steps <= LAT_STEPS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RADIUS:    radius    <= cfg_data[30:0];
        REG_CENTER_X:  center_x  <= cfg_data;
        REG_CENTER_Y:  center_y  <= cfg_data;
        REG_CENTER_Z:  center_z  <= cfg_data;
        REG_LON_STEPS: lon_steps <= cfg_data[7:0];
        REG_LAT_STEPS: lat_steps <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Advance every stage together unless the output register holds an untaken vertex.
  assign en    = !vertex_valid || vertex_ready;
  assign issue = busy && en;

  // Take a cell when idle, or the next cell while the last corner of the current one issues.
  assign cell_ready = !busy || (en && cnt == LAST_CORNER);

  assign lat_w = {12'b0, grid_cell.lat_index};
  assign lon_w = {12'b0, grid_cell.lon_index};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (cell_valid && cell_ready) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (issue) begin
      if (cnt == LAST_CORNER) begin
        busy <= 1'b0;
      end
      cnt <= cnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_valid && cell_ready) begin
      cell_i <= lat_w[INDEX_BITS-1:0];
      cell_j <= lon_w[INDEX_BITS-1:0];
    end
  end

  // Build the angle numerators for this corner; a zero step count divides by one.
  always_comb begin
    off       = corner_offset(cnt);
    va        = {1'b0, cell_i} + {{(AW-1){1'b0}}, off[0]};
    vb        = {1'b0, cell_j} + {{(AW-1){1'b0}}, off[1]};
    lon_div   = (lon_steps == 8'd0) ? 8'd1 : lon_steps;
    lat_div   = (lat_steps == 8'd0) ? 8'd1 : lat_steps;
    num_phi   = {vb, {ANGLE_W{1'b0}}};
    num_theta = {1'b0, va, {(ANGLE_W-1){1'b0}}};
    seq_tag.valid  = busy;
    seq_tag.corner = cnt;
  end

  uvst_divider #(
    .NUM_BITS (NUM_BITS)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .tag_in    (seq_tag),
    .num_phi   (num_phi),
    .num_theta (num_theta),
    .div_phi   (lon_div),
    .div_theta (lat_div),
    .tag_out   (div_tag),
    .q_phi     (q_phi),
    .q_theta   (q_theta)
  );

  // Latitude angle runs down from the north pole; wraps as a binary angle.
  assign theta = QUARTER_TURN - q_theta;

  uvst_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .tag_in    (div_tag),
    .ang_theta (theta),
    .ang_phi   (q_phi),
    .tag_out   (cor_tag),
    .sc_theta  (sc_theta),
    .sc_phi    (sc_phi)
  );

  uvst_vertex_math u_vertex_math (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .tag_in       (cor_tag),
    .sc_theta     (sc_theta),
    .sc_phi       (sc_phi),
    .radius       (radius),
    .center_x     (center_x),
    .center_y     (center_y),
    .center_z     (center_z),
    .vertex_valid (vertex_valid),
    .vertex       (vertex)
  );

  // No new cell while a cell still has corners to issue.
  a_no_accept_mid_cell: assert property (@(posedge clk) disable iff (rst)
    busy && cnt != LAST_CORNER |-> !cell_ready)
    else $error("cell accepted before all corners issued");

  // Sequencer corner count stays in the six-corner range.
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt <= LAST_CORNER)
    else $error("corner counter out of range");

  // Issuing the last corner without a new cell leaves the sequencer idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    issue && cnt == LAST_CORNER && !cell_valid |=> !busy)
    else $error("sequencer busy after last corner");

endmodule
`default_nettype wire
